### hw/rtl/rlmf_pkg.sv
// ----------------------------------------------------------------------------
// rlmf_pkg
// Shared types, widths and helpers of the 3x3 median-brightness filter.
// ----------------------------------------------------------------------------
package rlmf_pkg;

    localparam int PIX_W       = 24;
    localparam int WID_W       = 12;
    localparam int HGT_W       = 13;
    localparam int OUT_ROW_W   = 12;
    localparam int OUT_COL_W   = 11;
    localparam int BRI_W       = 8;
    localparam int WIN_N       = 9;
    localparam int RANK_W      = 4;
    localparam int MED_RANK    = 4;
    localparam int CFG_IDX_W   = 4;
    localparam int CFG_DATA_W  = 13;
    localparam int M_TDATA_W   = 48;
    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 4096;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;

    localparam logic [WID_W-1:0] WIDTH_RST  = 12'd640;
    localparam logic [HGT_W-1:0] HEIGHT_RST = 13'd480;

    // Output coordinates produced by one window
    typedef struct packed {
        logic [HGT_W-1:0] row0;
        logic [HGT_W-1:0] row1;
        logic [HGT_W-1:0] row2;
        logic [WID_W-1:0] col0;
        logic [WID_W-1:0] col1;
        logic [WID_W-1:0] col2;
        logic [1:0]       nr;
        logic [1:0]       nc;
        logic             frame_end;
    } rlmf_tgt_t;

    typedef logic [WIN_N-1:0][PIX_W-1:0] rlmf_win_t;

    // (b+g+r)/3; sum <= 765 so *683>>11 is exact
    function automatic logic [BRI_W-1:0] bright(input logic [PIX_W-1:0] pix);
        logic [9:0]  sum;
        logic [19:0] prod;
        sum  = 10'(pix[7:0]) + 10'(pix[15:8]) + 10'(pix[23:16]);
        prod = 20'(sum) * 20'd683;
        return prod[18:11];
    endfunction

endpackage

### hw/rtl/rlmf_ram.sv
// ----------------------------------------------------------------------------
// rlmf_ram
// Simple dual-port RAM, one write and one registered read port, read-first.
// ----------------------------------------------------------------------------
module rlmf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/rlmf_median.sv
// ----------------------------------------------------------------------------
// rlmf_median
// Brightness stage (registered) followed by rank selection of the window.
// ----------------------------------------------------------------------------
module rlmf_median (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           adv,
    input  logic                           in_valid,
    input  rlmf_pkg::rlmf_win_t            win,
    input  rlmf_pkg::rlmf_tgt_t            in_tgt,
    output logic                           out_valid,
    output logic [rlmf_pkg::PIX_W-1:0]     out_pix,
    output rlmf_pkg::rlmf_tgt_t            out_tgt
);

    logic                                                   valid_reg;
    rlmf_pkg::rlmf_win_t                                    cells_reg;
    logic [rlmf_pkg::WIN_N-1:0][rlmf_pkg::BRI_W-1:0]        bri_reg;
    rlmf_pkg::rlmf_tgt_t                                    tgt_reg;
    logic [rlmf_pkg::WIN_N-1:0][rlmf_pkg::RANK_W-1:0]       ahead;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cells_reg <= win;
            tgt_reg   <= in_tgt;
            for (int i = 0; i < rlmf_pkg::WIN_N; i++) begin
                bri_reg[i] <= rlmf_pkg::bright(win[i]);
            end
        end
    end

    // stable descending rank: brighter, or equal and earlier in scan order
    always_comb begin
        for (int i = 0; i < rlmf_pkg::WIN_N; i++) begin
            ahead[i] = '0;
            for (int j = 0; j < rlmf_pkg::WIN_N; j++) begin
                if ((bri_reg[j] > bri_reg[i]) || ((bri_reg[j] == bri_reg[i]) && (j < i))) begin
                    ahead[i] = ahead[i] + 1'b1;
                end
            end
        end
    end

    always_comb begin
        out_pix = cells_reg[rlmf_pkg::MED_RANK];
        for (int i = 0; i < rlmf_pkg::WIN_N; i++) begin
            if (ahead[i] == rlmf_pkg::RANK_W'(rlmf_pkg::MED_RANK)) begin
                out_pix = cells_reg[i];
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_tgt   = tgt_reg;

endmodule

### hw/rtl/rlmf_burst.sv
// ----------------------------------------------------------------------------
// rlmf_burst
// Output register; expands one median into its list of output coordinates.
// ----------------------------------------------------------------------------
module rlmf_burst (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                in_valid,
    input  logic [rlmf_pkg::PIX_W-1:0]          in_pix,
    input  rlmf_pkg::rlmf_tgt_t                 in_tgt,
    output logic                                in_ready,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [rlmf_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                                m_tlast,
    output logic                                m_tuser
);

    logic                          valid_reg, valid_next;
    logic [rlmf_pkg::PIX_W-1:0]    pix_reg;
    rlmf_pkg::rlmf_tgt_t           tgt_reg;
    logic [1:0]                    i_reg, i_next;
    logic [1:0]                    j_reg, j_next;
    logic                          row_end, col_end, last;
    logic                          load;
    logic [rlmf_pkg::HGT_W-1:0]    row_sel;
    logic [rlmf_pkg::WID_W-1:0]    col_sel;

    assign row_end  = (i_reg == tgt_reg.nr - 2'd1);
    assign col_end  = (j_reg == tgt_reg.nc - 2'd1);
    assign last     = row_end && col_end;
    assign in_ready = !valid_reg || (m_tready && last);
    assign load     = in_valid && in_ready;

    always_comb begin
        valid_next = valid_reg;
        i_next     = i_reg;
        j_next     = j_reg;
        if (valid_reg && m_tready) begin
            if (last) begin
                valid_next = 1'b0;
            end else if (col_end) begin
                i_next = i_reg + 2'd1;
                j_next = 2'd0;
            end else begin
                j_next = j_reg + 2'd1;
            end
        end
        if (load) begin
            valid_next = 1'b1;
            i_next     = 2'd0;
            j_next     = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            i_reg     <= 2'd0;
            j_reg     <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            i_reg     <= i_next;
            j_reg     <= j_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pix_reg <= in_pix;
            tgt_reg <= in_tgt;
        end
    end

    always_comb begin
        case (i_reg)
            2'd0:    row_sel = tgt_reg.row0;
            2'd1:    row_sel = tgt_reg.row1;
            default: row_sel = tgt_reg.row2;
        endcase
        case (j_reg)
            2'd0:    col_sel = tgt_reg.col0;
            2'd1:    col_sel = tgt_reg.col1;
            default: col_sel = tgt_reg.col2;
        endcase
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {1'b0, col_sel[rlmf_pkg::OUT_COL_W-1:0],
                       row_sel[rlmf_pkg::OUT_ROW_W-1:0], pix_reg};
    assign m_tlast  = last;
    assign m_tuser  = tgt_reg.frame_end && last;

endmodule

### hw/rtl/rgb_luma_median_filter_3x3_top.sv
// ----------------------------------------------------------------------------
// rgb_luma_median_filter_3x3_top
// 3x3 median-brightness filter over an RGB raster stream.
// ----------------------------------------------------------------------------
// Pixels enter on s_* in raster order, one transfer per pixel. Each result
// on m_* is the window pixel of median brightness (r+g+b)/3 with its row and
// column; the window is clamped so it stays inside the image. m_tlast marks
// the last result caused by one input pixel, m_tuser the final pixel of the
// image. Near the borders one input gives up to 9 results in a burst.
// Image geometry must be written on cfg_* only while idle; the block does not
// enforce this. A width or height write also restarts the frame at row 0,
// column 0. A result passes the input, window, brightness and output
// registers after the transfer of the pixel that completes its window.
// Throughput: one pixel per cycle while s_tready is high, limited by the
// one-per-cycle read of the two line-store RAMs; a burst can hold it low.
// When the receiver stalls, the four pipeline stages keep filling until the
// stage before the output register holds a result, then s_tready goes low.
// Reset clears positions and sets 640x480; line stores are not cleared.
// ----------------------------------------------------------------------------
module rgb_luma_median_filter_3x3_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    // pixel_bgr[23:0]
    input  logic [rlmf_pkg::PIX_W-1:0]          s_tdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // median_bgr[23:0], out_row[35:24], out_col[46:36], zero[47]
    output logic [rlmf_pkg::M_TDATA_W-1:0]      m_tdata,
    // run_last
    output logic                                m_tlast,
    // frame_last
    output logic                                m_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rlmf_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rlmf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int ADDR_W = $clog2(rlmf_pkg::MAX_WIDTH);

    logic [rlmf_pkg::WID_W-1:0]     width_reg, width_next;
    logic [rlmf_pkg::HGT_W-1:0]     height_reg, height_next;
    logic [rlmf_pkg::WID_W-1:0]     col_reg, col_next;
    logic [rlmf_pkg::HGT_W-1:0]     row_reg, row_next;
    logic                           cfg_wr, cfg_known;
    logic                           accept, adv;
    logic                           d_valid, e_ready;
    logic [rlmf_pkg::PIX_W-1:0]     d_pix;
    rlmf_pkg::rlmf_tgt_t            d_tgt;

    logic                           b_valid_reg;
    logic [rlmf_pkg::PIX_W-1:0]     b_pix_reg;
    logic [rlmf_pkg::WID_W-1:0]     b_col_reg;
    logic [rlmf_pkg::HGT_W-1:0]     b_row_reg;
    logic [rlmf_pkg::PIX_W-1:0]     up_data, lo_data;
    logic                           b_move;

    rlmf_pkg::rlmf_win_t            win_reg;
    logic                           c_valid_reg;
    rlmf_pkg::rlmf_tgt_t            c_tgt_reg;
    rlmf_pkg::rlmf_tgt_t            b_tgt;
    logic                           zr, er, zc, ec, emit;

    // ---------------- configuration ----------------
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_known = (cfg_index == rlmf_pkg::REG_IMAGE_WIDTH) ||
                       (cfg_index == rlmf_pkg::REG_IMAGE_HEIGHT);

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr && (cfg_index == rlmf_pkg::REG_IMAGE_WIDTH)) begin
            if (cfg_data[rlmf_pkg::WID_W-1:0] < rlmf_pkg::WID_W'(3)) begin
                width_next = rlmf_pkg::WID_W'(3);
            end else if (32'(cfg_data[rlmf_pkg::WID_W-1:0]) > rlmf_pkg::MAX_WIDTH) begin
                width_next = rlmf_pkg::WID_W'(rlmf_pkg::MAX_WIDTH);
            end else begin
                width_next = cfg_data[rlmf_pkg::WID_W-1:0];
            end
        end
        if (cfg_wr && (cfg_index == rlmf_pkg::REG_IMAGE_HEIGHT)) begin
            if (cfg_data < rlmf_pkg::HGT_W'(3)) begin
                height_next = rlmf_pkg::HGT_W'(3);
            end else if (32'(cfg_data) > rlmf_pkg::MAX_HEIGHT) begin
                height_next = rlmf_pkg::HGT_W'(rlmf_pkg::MAX_HEIGHT);
            end else begin
                height_next = cfg_data;
            end
        end
    end

    // ---------------- input position ----------------
    assign adv    = !d_valid || e_ready;
    assign accept = s_tvalid && s_tready;
    assign s_tready = adv;

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (cfg_wr && cfg_known) begin
            col_next = '0;
            row_next = '0;
        end else if (accept) begin
            if (({1'b0, col_reg} + 1'b1) >= {1'b0, width_reg}) begin
                col_next = '0;
                if (({1'b0, row_reg} + 1'b1) >= {1'b0, height_reg}) begin
                    row_next = '0;
                end else begin
                    row_next = row_reg + 1'b1;
                end
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= rlmf_pkg::WIDTH_RST;
            height_reg <= rlmf_pkg::HEIGHT_RST;
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    // ---------------- line stores ----------------
    assign b_move = b_valid_reg && adv;

    rlmf_ram #(
        .WIDTH (rlmf_pkg::PIX_W),
        .DEPTH (rlmf_pkg::MAX_WIDTH)
    ) u_upper (
        .aclk  (aclk),
        .we    (b_move),
        .waddr (ADDR_W'(b_col_reg)),
        .wdata (lo_data),
        .re    (accept),
        .raddr (ADDR_W'(col_reg)),
        .rdata (up_data)
    );

    rlmf_ram #(
        .WIDTH (rlmf_pkg::PIX_W),
        .DEPTH (rlmf_pkg::MAX_WIDTH)
    ) u_lower (
        .aclk  (aclk),
        .we    (b_move),
        .waddr (ADDR_W'(b_col_reg)),
        .wdata (b_pix_reg),
        .re    (accept),
        .raddr (ADDR_W'(col_reg)),
        .rdata (lo_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            b_pix_reg <= s_tdata;
            b_col_reg <= col_reg;
            b_row_reg <= row_reg;
        end
    end

    // ---------------- window and target list ----------------
    assign zr   = (b_row_reg == rlmf_pkg::HGT_W'(2));
    assign er   = (b_row_reg == height_reg - 1'b1);
    assign zc   = (b_col_reg == rlmf_pkg::WID_W'(2));
    assign ec   = (b_col_reg == width_reg - 1'b1);
    assign emit = (b_row_reg >= rlmf_pkg::HGT_W'(2)) && (b_col_reg >= rlmf_pkg::WID_W'(2));

    always_comb begin
        b_tgt.row0      = zr ? '0 : b_row_reg - 1'b1;
        b_tgt.row1      = zr ? rlmf_pkg::HGT_W'(1) : b_row_reg;
        b_tgt.row2      = b_row_reg;
        b_tgt.col0      = zc ? '0 : b_col_reg - 1'b1;
        b_tgt.col1      = zc ? rlmf_pkg::WID_W'(1) : b_col_reg;
        b_tgt.col2      = b_col_reg;
        b_tgt.nr        = 2'd1 + {1'b0, zr} + {1'b0, er};
        b_tgt.nc        = 2'd1 + {1'b0, zc} + {1'b0, ec};
        b_tgt.frame_end = er && ec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= 1'b0;
        end else if (adv) begin
            c_valid_reg <= b_valid_reg && emit;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_move) begin
            win_reg[0] <= win_reg[1];
            win_reg[1] <= win_reg[2];
            win_reg[2] <= up_data;
            win_reg[3] <= win_reg[4];
            win_reg[4] <= win_reg[5];
            win_reg[5] <= lo_data;
            win_reg[6] <= win_reg[7];
            win_reg[7] <= win_reg[8];
            win_reg[8] <= b_pix_reg;
            c_tgt_reg  <= b_tgt;
        end
    end

    // ---------------- median and output ----------------
    rlmf_median u_median (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (c_valid_reg),
        .win       (win_reg),
        .in_tgt    (c_tgt_reg),
        .out_valid (d_valid),
        .out_pix   (d_pix),
        .out_tgt   (d_tgt)
    );

    rlmf_burst u_burst (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (d_valid),
        .in_pix   (d_pix),
        .in_tgt   (d_tgt),
        .in_ready (e_ready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // ---------------- assertions ----------------
    a_frame_end_is_run_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame end not on last result of a run");

    a_cfg_restarts_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_wr && cfg_known |=> (col_reg == '0) && (row_reg == '0))
        else $error("register write did not restart frame");

    a_position_in_image: assert property (@(posedge aclk) disable iff (!aresetn)
        (col_reg < width_reg) && (row_reg < height_reg))
        else $error("position outside image");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> d_valid && m_tvalid)
        else $error("input stalled with free output stage");

endmodule
